// ----- design/cigar_coverage_accumulator_macros.svh -----
// assertion helpers for the coverage accumulator checker
`ifndef CIGAR_COVERAGE_ACCUMULATOR_MACROS_SVH
`define CIGAR_COVERAGE_ACCUMULATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CCOV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define CCOV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ccov_pkg.sv -----
// ----------------------------------------------------------------------------
// ccov_pkg
// Shared constants, types and the microcode table of the coverage accumulator.
// ----------------------------------------------------------------------------
package ccov_pkg;

  localparam int COVERAGE_WORDS = 65536;
  localparam int MAX_SEGMENTS   = 1024;
  // coverage store is addressed modulo its depth, which is a power of two
  localparam int COV_AW         = $clog2(COVERAGE_WORDS);
  localparam int SEG_AW         = $clog2(MAX_SEGMENTS);

  localparam int CMD_W    = 3;
  localparam int SEG_W    = 10;
  localparam int BASE_W   = 16;
  localparam int LEN_W    = 17;
  localparam int START_W  = 16;
  localparam int OP_W     = 4;
  localparam int OPLEN_W  = 28;
  localparam int ADDR_W   = 16;
  localparam int COV_W    = 8;
  localparam int POS_W    = 33;
  localparam int ACC_W    = 48;
  localparam int READS_W  = 32;
  localparam int STEP_W   = 4;

  localparam logic [POS_W-1:0]   POS_MAX   = '1;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;
  localparam logic [READS_W-1:0] READS_MAX = '1;
  localparam logic [COV_W-1:0]   COV_MAX   = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN      = 3'd0,
    CMD_CIGAR      = 3'd1,
    CMD_END        = 3'd2,
    CMD_READ_COV   = 3'd3,
    CMD_READ_TOTAL = 3'd4
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_M  = 4'd0,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } cigar_op_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_LOAD_REC,
    ACT_OP_SUM,
    ACT_OP_LIMIT,
    ACT_COV_STEP,
    ACT_POS_UPD,
    ACT_SEG_READ,
    ACT_SEG_WRITE,
    ACT_COV_READ,
    ACT_OUT
  } act_e;

  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_DISPATCH,
    CND_CLR_MORE,
    CND_NOT_MATCH,
    CND_NO_SPAN,
    CND_LOOP_MORE
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_CLEAR   = 4'd0;
  localparam step_t STEP_IDLE    = 4'd1;
  localparam step_t STEP_BEGIN   = 4'd2;
  localparam step_t STEP_C_SUM   = 4'd3;
  localparam step_t STEP_C_LIMIT = 4'd4;
  localparam step_t STEP_C_LOOP  = 4'd5;
  localparam step_t STEP_C_POS   = 4'd6;
  localparam step_t STEP_E_READ  = 4'd7;
  localparam step_t STEP_E_WRITE = 4'd8;
  localparam step_t STEP_R_COV   = 4'd9;
  localparam step_t STEP_R_TOTAL = 4'd10;
  localparam step_t STEP_OUT     = 4'd11;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic clr_more;
    logic not_match;
    logic no_span;
    logic loop_more;
  } flags_t;

  function automatic ctrl_word_t ucode(step_t step);
    ctrl_word_t cw;
    unique case (step)
      STEP_CLEAR:   cw = '{ACT_CLEAR,     CND_CLR_MORE,  STEP_CLEAR};
      STEP_IDLE:    cw = '{ACT_NONE,      CND_DISPATCH,  STEP_IDLE};
      STEP_BEGIN:   cw = '{ACT_LOAD_REC,  CND_ALWAYS,    STEP_OUT};
      STEP_C_SUM:   cw = '{ACT_OP_SUM,    CND_NOT_MATCH, STEP_C_POS};
      STEP_C_LIMIT: cw = '{ACT_OP_LIMIT,  CND_NO_SPAN,   STEP_C_POS};
      STEP_C_LOOP:  cw = '{ACT_COV_STEP,  CND_LOOP_MORE, STEP_C_LOOP};
      STEP_C_POS:   cw = '{ACT_POS_UPD,   CND_ALWAYS,    STEP_OUT};
      STEP_E_READ:  cw = '{ACT_SEG_READ,  CND_NEXT,      STEP_E_WRITE};
      STEP_E_WRITE: cw = '{ACT_SEG_WRITE, CND_ALWAYS,    STEP_OUT};
      STEP_R_COV:   cw = '{ACT_COV_READ,  CND_ALWAYS,    STEP_OUT};
      STEP_R_TOTAL: cw = '{ACT_SEG_READ,  CND_ALWAYS,    STEP_OUT};
      STEP_OUT:     cw = '{ACT_OUT,       CND_ALWAYS,    STEP_IDLE};
      default:      cw = '{ACT_NONE,      CND_ALWAYS,    STEP_IDLE};
    endcase
    return cw;
  endfunction

  function automatic step_t dispatch(logic [CMD_W-1:0] cmd);
    step_t s;
    unique case (cmd)
      CMD_BEGIN:      s = STEP_BEGIN;
      CMD_CIGAR:      s = STEP_C_SUM;
      CMD_END:        s = STEP_E_READ;
      CMD_READ_COV:   s = STEP_R_COV;
      CMD_READ_TOTAL: s = STEP_R_TOTAL;
      default:        s = STEP_OUT;
    endcase
    return s;
  endfunction

endpackage

// ----- design/ccov_sequencer.sv -----
// ----------------------------------------------------------------------------
// ccov_sequencer
// Step counter over the microcode table, with conditional and dispatch jumps.
// ----------------------------------------------------------------------------
module ccov_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [ccov_pkg::CMD_W-1:0]   command_i,
  input  ccov_pkg::flags_t             flags_i,
  output ccov_pkg::act_e               act_o,
  output logic                         accept_o,
  output logic                         busy_o
);

  ccov_pkg::step_t      pc_q, pc_d;
  ccov_pkg::ctrl_word_t cw;

  assign cw       = ccov_pkg::ucode(pc_q);
  assign act_o    = cw.act;
  assign busy_o   = (pc_q != ccov_pkg::STEP_IDLE);
  assign accept_o = start && !busy_o;

  always_comb begin
    unique case (cw.cond)
      ccov_pkg::CND_NEXT:      pc_d = pc_q + 1'b1;
      ccov_pkg::CND_ALWAYS:    pc_d = cw.target;
      ccov_pkg::CND_DISPATCH:  pc_d = accept_o ? ccov_pkg::dispatch(command_i) : pc_q;
      ccov_pkg::CND_CLR_MORE:  pc_d = flags_i.clr_more  ? cw.target : pc_q + 1'b1;
      ccov_pkg::CND_NOT_MATCH: pc_d = flags_i.not_match ? cw.target : pc_q + 1'b1;
      ccov_pkg::CND_NO_SPAN:   pc_d = flags_i.no_span   ? cw.target : pc_q + 1'b1;
      ccov_pkg::CND_LOOP_MORE: pc_d = flags_i.loop_more ? cw.target : pc_q + 1'b1;
      default:                 pc_d = ccov_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ccov_pkg::STEP_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- design/cigar_coverage_accumulator.sv -----
// ----------------------------------------------------------------------------
// cigar_coverage_accumulator
// Per-base coverage pileup and per-segment totals from cigar alignment records.
// ----------------------------------------------------------------------------
// from accept to result strobe: begin and both reads run their own step, unknown
//   commands go straight to the output step, end reads then writes the segment tables,
//   a cigar op sums then moves the position, and a matching op in between does one
//   store update per cycle for each covered base inside the segment
// a new item can be started in the cycle the result strobe is high; after reset the
//   block is busy zeroing the coverage store and the segment tables, one entry per cycle
module cigar_coverage_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ccov_pkg::CMD_W-1:0]      command_i,
  input  logic [ccov_pkg::SEG_W-1:0]      segment_id_i,
  input  logic [ccov_pkg::BASE_W-1:0]     segment_base_i,
  input  logic [ccov_pkg::LEN_W-1:0]      segment_length_i,
  input  logic [ccov_pkg::START_W-1:0]    start_position_i,
  input  logic [ccov_pkg::OP_W-1:0]       cigar_op_i,
  input  logic [ccov_pkg::OPLEN_W-1:0]    op_length_i,
  input  logic [ccov_pkg::ADDR_W-1:0]     coverage_address_i,
  output logic                            done_o,
  output logic [ccov_pkg::COV_W-1:0]      coverage_value_o,
  output logic [ccov_pkg::ACC_W-1:0]      total_bases_o,
  output logic [ccov_pkg::READS_W-1:0]    read_count_o,
  output logic [ccov_pkg::ACC_W-1:0]      record_aligned_bases_o
);

  localparam int PosSumW   = ccov_pkg::POS_W + 1;
  localparam int AccSumW   = ccov_pkg::ACC_W + 1;
  localparam int IdxSumW   = ccov_pkg::LEN_W + 1;

  ccov_pkg::act_e   act;
  ccov_pkg::flags_t flags;
  logic             accept;

  // latched item
  logic [ccov_pkg::CMD_W-1:0]    in_cmd_q;
  logic [ccov_pkg::SEG_W-1:0]    in_seg_q;
  logic [ccov_pkg::BASE_W-1:0]   in_base_q;
  logic [ccov_pkg::LEN_W-1:0]    in_len_q;
  logic [ccov_pkg::START_W-1:0]  in_start_q;
  logic [ccov_pkg::OP_W-1:0]     in_op_q;
  logic [ccov_pkg::OPLEN_W-1:0]  in_oplen_q;
  logic [ccov_pkg::ADDR_W-1:0]   in_addr_q;

  // record state
  logic [ccov_pkg::SEG_W-1:0]    cur_seg_q;
  logic [ccov_pkg::BASE_W-1:0]   cur_base_q;
  logic [ccov_pkg::LEN_W-1:0]    cur_len_q;
  logic [ccov_pkg::POS_W-1:0]    pos_q;
  logic [ccov_pkg::ACC_W-1:0]    acc_q;

  // op working registers
  logic [ccov_pkg::POS_W-1:0]    sum_q;
  logic [ccov_pkg::LEN_W-1:0]    stop_q;
  logic [ccov_pkg::LEN_W-1:0]    idx_q;

  logic                          wb_valid_q;
  logic [ccov_pkg::COV_AW-1:0]   wb_addr_q;
  logic [ccov_pkg::COV_AW-1:0]   clr_cnt_q;

  logic [ccov_pkg::COV_W-1:0]    cov_mem [ccov_pkg::COVERAGE_WORDS];
  logic [ccov_pkg::ACC_W-1:0]    tot_mem [ccov_pkg::MAX_SEGMENTS];
  logic [ccov_pkg::READS_W-1:0]  rds_mem [ccov_pkg::MAX_SEGMENTS];
  logic [ccov_pkg::COV_W-1:0]    cov_rdata_q;
  logic [ccov_pkg::ACC_W-1:0]    tot_rdata_q;
  logic [ccov_pkg::READS_W-1:0]  rds_rdata_q;

  logic                          done_q;
  logic [ccov_pkg::COV_W-1:0]    cov_out_q;
  logic [ccov_pkg::ACC_W-1:0]    tot_out_q;
  logic [ccov_pkg::READS_W-1:0]  rds_out_q;
  logic [ccov_pkg::ACC_W-1:0]    rec_out_q;

  ccov_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .flags_i   (flags),
    .act_o     (act),
    .accept_o  (accept),
    .busy_o    (busy)
  );

  // ---------------- op decode and arithmetic ----------------
  logic                          is_match, is_skip;
  logic [PosSumW-1:0]            pos_sum;
  logic [ccov_pkg::POS_W-1:0]    pos_sat;
  logic [AccSumW-1:0]            acc_sum;
  logic [ccov_pkg::ACC_W-1:0]    acc_sat;
  logic [ccov_pkg::LEN_W-1:0]    stop_c;
  logic [IdxSumW-1:0]            idx_next;
  logic [ccov_pkg::COV_AW-1:0]   loop_addr;

  assign is_match = (in_op_q == ccov_pkg::OP_M) || (in_op_q == ccov_pkg::OP_EQ) ||
                    (in_op_q == ccov_pkg::OP_X);
  assign is_skip  = (in_op_q == ccov_pkg::OP_D) || (in_op_q == ccov_pkg::OP_N);

  assign pos_sum = {1'b0, pos_q} + PosSumW'(in_oplen_q);
  assign pos_sat = (pos_sum > PosSumW'(ccov_pkg::POS_MAX)) ? ccov_pkg::POS_MAX
                                                           : pos_sum[ccov_pkg::POS_W-1:0];
  assign acc_sum = {1'b0, acc_q} + AccSumW'(in_oplen_q);
  assign acc_sat = (acc_sum > AccSumW'(ccov_pkg::ACC_MAX)) ? ccov_pkg::ACC_MAX
                                                           : acc_sum[ccov_pkg::ACC_W-1:0];

  // covered span ends at the op end or the segment end, whichever is first
  assign stop_c = (sum_q > ccov_pkg::POS_W'(cur_len_q)) ? cur_len_q
                                                         : sum_q[ccov_pkg::LEN_W-1:0];
  assign idx_next  = IdxSumW'(idx_q) + 1'b1;
  // address wraps modulo the store depth
  assign loop_addr = ccov_pkg::COV_AW'(IdxSumW'(cur_base_q) + IdxSumW'(idx_q));

  assign flags.clr_more  = (clr_cnt_q != ccov_pkg::COV_AW'(ccov_pkg::COVERAGE_WORDS - 1));
  assign flags.not_match = !is_match;
  assign flags.no_span   = (pos_q >= ccov_pkg::POS_W'(stop_c));
  assign flags.loop_more = (idx_next < IdxSumW'(stop_q));

  // ---------------- range checks ----------------
  logic cov_addr_ok, qseg_ok, cseg_ok;
  assign cov_addr_ok = (32'(in_addr_q) < ccov_pkg::COVERAGE_WORDS);
  assign qseg_ok     = (32'(in_seg_q)  < ccov_pkg::MAX_SEGMENTS);
  assign cseg_ok     = (32'(cur_seg_q) < ccov_pkg::MAX_SEGMENTS);

  // ---------------- coverage store ----------------
  logic                          cov_we;
  logic [ccov_pkg::COV_AW-1:0]   cov_waddr, cov_raddr;
  logic [ccov_pkg::COV_W-1:0]    cov_wdata;

  always_comb begin
    cov_we    = 1'b0;
    cov_waddr = wb_addr_q;
    cov_wdata = (cov_rdata_q == ccov_pkg::COV_MAX) ? ccov_pkg::COV_MAX
                                                   : cov_rdata_q + 1'b1;
    if (act == ccov_pkg::ACT_CLEAR) begin
      cov_we    = 1'b1;
      cov_waddr = clr_cnt_q;
      cov_wdata = '0;
    end else if (wb_valid_q) begin
      cov_we = 1'b1;
    end
  end

  assign cov_raddr = (act == ccov_pkg::ACT_COV_READ) ? in_addr_q[ccov_pkg::COV_AW-1:0]
                                                     : loop_addr;

  always_ff @(posedge clk_i) begin
    if (cov_we) begin
      cov_mem[cov_waddr] <= cov_wdata;
    end
    cov_rdata_q <= cov_mem[cov_raddr];
  end

  // ---------------- segment tables ----------------
  logic                          seg_we;
  logic [ccov_pkg::SEG_AW-1:0]   seg_waddr, seg_raddr;
  logic [ccov_pkg::ACC_W-1:0]    tot_wdata;
  logic [ccov_pkg::READS_W-1:0]  rds_wdata;
  logic [AccSumW-1:0]            tot_sum;

  assign tot_sum = {1'b0, tot_rdata_q} + {1'b0, acc_q};

  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = cur_seg_q[ccov_pkg::SEG_AW-1:0];
    tot_wdata = (tot_sum > AccSumW'(ccov_pkg::ACC_MAX)) ? ccov_pkg::ACC_MAX
                                                        : tot_sum[ccov_pkg::ACC_W-1:0];
    rds_wdata = (rds_rdata_q == ccov_pkg::READS_MAX) ? ccov_pkg::READS_MAX
                                                     : rds_rdata_q + 1'b1;
    if (act == ccov_pkg::ACT_CLEAR) begin
      seg_we    = (32'(clr_cnt_q) < ccov_pkg::MAX_SEGMENTS);
      seg_waddr = clr_cnt_q[ccov_pkg::SEG_AW-1:0];
      tot_wdata = '0;
      rds_wdata = '0;
    end else if (act == ccov_pkg::ACT_SEG_WRITE) begin
      seg_we = cseg_ok;
    end
  end

  assign seg_raddr = (in_cmd_q == ccov_pkg::CMD_END) ? cur_seg_q[ccov_pkg::SEG_AW-1:0]
                                                     : in_seg_q[ccov_pkg::SEG_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      tot_mem[seg_waddr] <= tot_wdata;
      rds_mem[seg_waddr] <= rds_wdata;
    end
    tot_rdata_q <= tot_mem[seg_raddr];
    rds_rdata_q <= rds_mem[seg_raddr];
  end

  // ---------------- item latch ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q   <= command_i;
      in_seg_q   <= segment_id_i;
      in_base_q  <= segment_base_i;
      in_len_q   <= segment_length_i;
      in_start_q <= start_position_i;
      in_op_q    <= cigar_op_i;
      in_oplen_q <= op_length_i;
      in_addr_q  <= coverage_address_i;
    end
  end

  // op working registers carry payload only
  always_ff @(posedge clk_i) begin
    if (act == ccov_pkg::ACT_OP_SUM) begin
      sum_q <= pos_sat;
    end
    if (act == ccov_pkg::ACT_OP_LIMIT) begin
      stop_q <= stop_c;
      idx_q  <= pos_q[ccov_pkg::LEN_W-1:0];
    end else if (act == ccov_pkg::ACT_COV_STEP) begin
      idx_q  <= idx_next[ccov_pkg::LEN_W-1:0];
    end
    if (act == ccov_pkg::ACT_COV_STEP) begin
      wb_addr_q <= loop_addr;
    end
    if (act == ccov_pkg::ACT_OUT) begin
      cov_out_q <= (in_cmd_q == ccov_pkg::CMD_READ_COV && cov_addr_ok) ? cov_rdata_q : '0;
      tot_out_q <= (in_cmd_q == ccov_pkg::CMD_READ_TOTAL && qseg_ok) ? tot_rdata_q : '0;
      rds_out_q <= (in_cmd_q == ccov_pkg::CMD_READ_TOTAL && qseg_ok) ? rds_rdata_q : '0;
      rec_out_q <= acc_q;
    end
  end

  // ---------------- record state and control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seg_q  <= '0;
      cur_base_q <= '0;
      cur_len_q  <= '0;
      pos_q      <= '0;
      acc_q      <= '0;
      wb_valid_q <= 1'b0;
      clr_cnt_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      wb_valid_q <= (act == ccov_pkg::ACT_COV_STEP);
      done_q     <= (act == ccov_pkg::ACT_OUT);
      if (act == ccov_pkg::ACT_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (act == ccov_pkg::ACT_LOAD_REC) begin
        cur_seg_q  <= in_seg_q;
        cur_base_q <= in_base_q;
        cur_len_q  <= in_len_q;
        pos_q      <= ccov_pkg::POS_W'(in_start_q);
        acc_q      <= '0;
      end
      if (act == ccov_pkg::ACT_OP_SUM && is_match) begin
        acc_q <= acc_sat;
      end
      if (act == ccov_pkg::ACT_POS_UPD && (is_match || is_skip)) begin
        pos_q <= sum_q;
      end
    end
  end

  assign done_o                 = done_q;
  assign coverage_value_o       = cov_out_q;
  assign total_bases_o          = tot_out_q;
  assign read_count_o           = rds_out_q;
  assign record_aligned_bases_o = rec_out_q;

endmodule

// ----- design/ccov_checker.sv -----
// ----------------------------------------------------------------------------
// ccov_checker
// Port-level timing checks of the coverage accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "cigar_coverage_accumulator_macros.svh"

module ccov_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [ccov_pkg::CMD_W-1:0]   command_i
);

  // a transfer always makes the block busy in the next cycle
  `CCOV_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after transfer")

  // the result strobe only shows once the block is free again
  `CCOV_ASSERT_NOW(a_done_idle, done_o, !busy, "result strobe while busy")

  // a result strobe lasts one cycle, since a new item must pass its output step before its strobe
  `CCOV_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held")

  // every rising result strobe comes right after the block was busy
  `CCOV_ASSERT_NOW(a_done_after_work, $rose(done_o), $past(busy), "result without work")

  // a transfer of a read command gives a result after its read step and its output step
  `CCOV_ASSERT_NEXT(a_read_latency,
    start && !busy && (command_i == ccov_pkg::CMD_READ_COV ||
    command_i == ccov_pkg::CMD_READ_TOTAL), ##2 done_o, "read result late")

endmodule

bind cigar_coverage_accumulator ccov_checker u_ccov_checker (.*);
